// ----- rtl/core/texel_format_to_rgb8_core_macros.svh -----
// ----------------------------------------------------------------------------
// texel_format_to_rgb8_core_macros.svh
// assertion macros shared by the texel conversion core
// ----------------------------------------------------------------------------
`ifndef TEXEL_FORMAT_TO_RGB8_CORE_MACROS_SVH
`define TEXEL_FORMAT_TO_RGB8_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define TFRGB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tfrgb assertion failed");

// next-cycle implication, checked out of reset
`define TFRGB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tfrgb assertion failed");

`else

`define TFRGB_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TFRGB_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/core/tfrgb_pkg.sv -----
// ----------------------------------------------------------------------------
// tfrgb_pkg
// format codes, register map and half-float constants of the texel core
// ----------------------------------------------------------------------------
package tfrgb_pkg;

    // pixel format codes
    localparam logic [2:0] FMT_RGBA8       = 3'd0;
    localparam logic [2:0] FMT_BGRA8       = 3'd1;
    localparam logic [2:0] FMT_A2B10G10R10 = 3'd2;
    localparam logic [2:0] FMT_A2R10G10B10 = 3'd3;
    localparam logic [2:0] FMT_RGBA16F     = 3'd4;

    // register map
    localparam int unsigned CFG_ADDR_W    = 3;
    localparam logic        REG_PIXEL_FMT = 1'b0;

    // half float fields and conversion constants
    localparam logic [4:0] HALF_EXP_ONE     = 5'd15;
    localparam logic [4:0] HALF_EXP_ZERO    = 5'd0;
    localparam logic [4:0] HALF_SHIFT_BIAS  = 5'd25;
    localparam logic [4:0] HALF_SUBN_SHIFT  = 5'd24;
    localparam logic [7:0] CHAN_MAX         = 8'hff;

    typedef logic [15:0] half_t;
    typedef logic [7:0]  chan_t;

endpackage

// ----- rtl/core/tfrgb_half2u8.sv -----
// ----------------------------------------------------------------------------
// tfrgb_half2u8
// converts one half float to an 8-bit channel: value*255, rounded half up,
// clamped; a set sign bit gives 0, other infinity and nan give 255
// ----------------------------------------------------------------------------
module tfrgb_half2u8
    import tfrgb_pkg::*;
(
    input  half_t half_bits,
    output chan_t chan
);

    logic        sign;
    logic [4:0]  expo;
    logic [9:0]  man;
    logic [10:0] mant;
    logic [18:0] prod;
    logic [4:0]  shift;
    logic [24:0] rnd;
    logic [24:0] sum;
    logic [24:0] shifted;
    chan_t       scaled;

    assign sign = half_bits[15];
    assign expo = half_bits[14:10];
    assign man  = half_bits[9:0];

    // significand with hidden bit, times 255
    assign mant = {(expo != HALF_EXP_ZERO), man};
    assign prod = {mant, 8'd0} - {8'd0, mant};

    // right shift that applies the exponent and the 1/1024 scale
    assign shift = (expo == HALF_EXP_ZERO) ? HALF_SUBN_SHIFT : (HALF_SHIFT_BIAS - expo);

    // round half up, then clamp
    assign rnd     = 25'd1 << (shift - 5'd1);
    assign sum     = {6'd0, prod} + rnd;
    assign shifted = sum >> shift;
    assign scaled  = (shifted[24:8] != 17'd0) ? CHAN_MAX : shifted[7:0];

    // sign and large values
    always_comb begin
        if (sign) begin
            chan = 8'd0;
        end else if (expo >= HALF_EXP_ONE) begin
            chan = CHAN_MAX;
        end else begin
            chan = scaled;
        end
    end

endmodule

// ----- rtl/core/texel_format_to_rgb8_core.sv -----
// ----------------------------------------------------------------------------
// texel_format_to_rgb8_core
// unpacks one 64-bit texel under the configured pixel format into 8-bit
// red, green and blue
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  s_       in         s_valid / s_ready   s_texel_bits[63:0]
//  m_       out        m_valid / m_ready   m_red, m_green, m_blue, m_supported
//  apb      in         psel/penable/pready pixel_format at address 0
//
//  one item per cycle while m_ready is not stalling; an accepted item goes
//  through the input register, the conversion logic and the result register,
//  whose valid drives m_valid
//  reset clears both stage valids and sets the format to rgba8
//  a stall on m_ready holds the result and backs up into the input register;
//  s_ready drops only when both stages hold an item
// ----------------------------------------------------------------------------
`include "texel_format_to_rgb8_core_macros.svh"

module texel_format_to_rgb8_core
    import tfrgb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [63:0]           s_texel_bits,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_red,
    output logic [7:0]            m_green,
    output logic [7:0]            m_blue,
    output logic                  m_supported,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [2:0]  pixel_format_reg, pixel_format_next;
    logic        in_valid_reg, in_valid_next;
    logic [63:0] texel_reg, texel_next;
    logic        out_valid_reg, out_valid_next;
    chan_t       red_reg, red_next;
    chan_t       green_reg, green_next;
    chan_t       blue_reg, blue_next;
    logic        supported_reg, supported_next;

    logic        adv_out;
    logic        cfg_wr;
    chan_t       half_r, half_g, half_b;
    chan_t       c0, c1, c2;
    logic        rgb_zero;
    logic        in_held;
    logic        in_moves;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PIXEL_FMT);
    assign prdata = (paddr[2] == REG_PIXEL_FMT) ? {29'd0, pixel_format_reg} : 32'd0;
    assign pixel_format_next = cfg_wr ? pwdata[2:0] : pixel_format_reg;

    // handshake between the two stages
    assign adv_out = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || adv_out;

    // input register
    always_comb begin
        in_valid_next = in_valid_reg;
        texel_next    = texel_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            texel_next    = s_texel_bits;
        end
    end

    // half float channels
    tfrgb_half2u8 u_half_r (.half_bits(texel_reg[15:0]),  .chan(half_r));
    tfrgb_half2u8 u_half_g (.half_bits(texel_reg[31:16]), .chan(half_g));
    tfrgb_half2u8 u_half_b (.half_bits(texel_reg[47:32]), .chan(half_b));

    // top 8 bits of each 10-bit channel
    assign c0 = texel_reg[9:2];
    assign c1 = texel_reg[19:12];
    assign c2 = texel_reg[29:22];

    // format select into the result register
    always_comb begin
        out_valid_next = out_valid_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        supported_next = supported_reg;
        if (adv_out) begin
            out_valid_next = in_valid_reg;
            supported_next = 1'b1;
            case (pixel_format_reg)
                FMT_RGBA8: begin
                    red_next   = texel_reg[7:0];
                    green_next = texel_reg[15:8];
                    blue_next  = texel_reg[23:16];
                end
                FMT_BGRA8: begin
                    red_next   = texel_reg[23:16];
                    green_next = texel_reg[15:8];
                    blue_next  = texel_reg[7:0];
                end
                FMT_A2B10G10R10: begin
                    red_next   = c0;
                    green_next = c1;
                    blue_next  = c2;
                end
                FMT_A2R10G10B10: begin
                    red_next   = c2;
                    green_next = c1;
                    blue_next  = c0;
                end
                FMT_RGBA16F: begin
                    red_next   = half_r;
                    green_next = half_g;
                    blue_next  = half_b;
                end
                default: begin
                    red_next       = 8'd0;
                    green_next     = 8'd0;
                    blue_next      = 8'd0;
                    supported_next = 1'b0;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg <= FMT_RGBA8;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            pixel_format_reg <= pixel_format_next;
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        texel_reg     <= texel_next;
        red_reg       <= red_next;
        green_reg     <= green_next;
        blue_reg      <= blue_next;
        supported_reg <= supported_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_red       = red_reg;
    assign m_green     = green_reg;
    assign m_blue      = blue_reg;
    assign m_supported = supported_reg;

    // terms for the checks below
    assign rgb_zero = (m_red == 8'd0) && (m_green == 8'd0) && (m_blue == 8'd0);
    assign in_held  = in_valid_reg && !adv_out;
    assign in_moves = in_valid_reg && adv_out;

    // unknown format gives zero channels
    `TFRGB_ASSERT_IMP(a_unsup_zero, aclk, aresetn, m_valid && !m_supported, rgb_zero)
    // an accepted item lands in the input register
    `TFRGB_ASSERT_NXT(a_accept_fill, aclk, aresetn, s_valid && s_ready, in_valid_reg)
    // a blocked input stage keeps its item
    `TFRGB_ASSERT_NXT(a_stage_hold, aclk, aresetn, in_held, in_valid_reg && $stable(texel_reg))
    // a moving input stage feeds the result register
    `TFRGB_ASSERT_NXT(a_stage_move, aclk, aresetn, in_moves, m_valid)

endmodule
